// ===== hw/rtl/khtab_pkg.sv =====
// Shared types, constants and codes of the keyed generational handle table.
package khtab_pkg;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	localparam logic [1:0] CMD_UPSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_FIND   = 2'd2;
	localparam logic [1:0] CMD_HANDLE = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_DISABLED  = 3'd2;
	localparam logic [2:0] ST_ZERO_KEY  = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] key;
		logic [5:0]  handle_slot;
		logic [31:0] handle_generation;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        was_update;
		logic [5:0]  out_slot;
		logic [31:0] out_generation;
		logic [31:0] out_key;
		logic [31:0] record_revision;
		logic [6:0]  live_count;
		logic [31:0] table_revision;
	} rsp_t;

	typedef struct packed {
		logic [31:0]   key;
		logic [AW-1:0] slot;
	} idx_t;

	typedef struct packed {
		logic [31:0]   key;
		logic [AW-1:0] owner;
		logic [31:0]   rev;
	} rec_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_SRCH, S_SRCH_CMP, S_HIT_CMP, S_HSLOT_CMP, S_SLOT_CMP,
		S_REC_CMP, S_LAST_CMP, S_DEL_PREP, S_DEL_SHIFT, S_DEL_FIN, S_POP_CMP,
		S_POP_GEN, S_ALLOC, S_INS_SHIFT, S_INS_FIN
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_RES_DIS, OP_RES_NF, OP_RES_ZK, OP_RES_FULL, OP_HRD,
		OP_MID_RD, OP_SRCH_UPD, OP_HIT_RD, OP_SLOT_RD, OP_REC_RD, OP_RES_FIND,
		OP_RES_UPD, OP_DEL_START, OP_MOVE, OP_DEL_PREP, OP_DEL_SHIFT, OP_DEL_FIN,
		OP_POP_RD, OP_POP_GEN, OP_GEN_LATCH, OP_NEW_SLOT, OP_ALLOC, OP_INS_SHIFT,
		OP_INS_FIN
	} op_t;

	typedef struct packed {
		logic       enabled;
		logic [1:0] command;
		logic       key_zero;
		logic       handle_live;
		logic       gen_match;
		logic       n_zero;
		logic       hit;
		logic       free_avail;
		logic       slot_avail;
		logic       last_differs;
		logic       ins_first;
		logic       ins_more;
		logic       del_first;
		logic       del_more;
	} dp_stat_t;

endpackage

// ===== hw/rtl/khtab_ram.sv =====
// Generic single write port, single registered read port RAM.
module khtab_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/khtab_ctrl.sv =====
// Controller state machine of the handle table.
module khtab_ctrl import khtab_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output op_t      op,
	output logic     busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (!stat.enabled) state_d = S_IDLE;
				else if (stat.command == CMD_HANDLE)
					state_d = stat.handle_live ? S_HSLOT_CMP : S_IDLE;
				else if (stat.key_zero) state_d = S_IDLE;
				else state_d = S_SRCH;
			end
			S_SRCH:      state_d = stat.n_zero ? S_HIT_CMP : S_SRCH_CMP;
			S_SRCH_CMP:  state_d = S_SRCH;
			S_HIT_CMP: begin
				if (stat.hit) state_d = S_SLOT_CMP;
				else if (stat.command == CMD_UPSERT && stat.free_avail) state_d = S_POP_CMP;
				else if (stat.command == CMD_UPSERT && stat.slot_avail) state_d = S_ALLOC;
				else state_d = S_IDLE;
			end
			S_HSLOT_CMP: state_d = stat.gen_match ? S_REC_CMP : S_IDLE;
			S_SLOT_CMP:  state_d = S_REC_CMP;
			S_REC_CMP: begin
				if (stat.command == CMD_REMOVE)
					state_d = stat.last_differs ? S_LAST_CMP : S_DEL_PREP;
				else state_d = S_IDLE;
			end
			S_LAST_CMP:  state_d = S_DEL_PREP;
			S_DEL_PREP:  state_d = stat.del_first ? S_DEL_SHIFT : S_DEL_FIN;
			S_DEL_SHIFT: state_d = stat.del_more ? S_DEL_SHIFT : S_DEL_FIN;
			S_DEL_FIN:   state_d = S_IDLE;
			S_POP_CMP:   state_d = S_POP_GEN;
			S_POP_GEN:   state_d = S_ALLOC;
			S_ALLOC:     state_d = stat.ins_first ? S_INS_SHIFT : S_INS_FIN;
			S_INS_SHIFT: state_d = stat.ins_more ? S_INS_SHIFT : S_INS_FIN;
			S_INS_FIN:   state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) op = OP_LOAD;
			end
			S_DECODE: begin
				if (!stat.enabled) op = OP_RES_DIS;
				else if (stat.command == CMD_HANDLE)
					op = stat.handle_live ? OP_HRD : OP_RES_NF;
				else if (stat.key_zero) op = OP_RES_ZK;
				else op = OP_NONE;
			end
			S_SRCH:      op = stat.n_zero ? OP_HIT_RD : OP_MID_RD;
			S_SRCH_CMP:  op = OP_SRCH_UPD;
			S_HIT_CMP: begin
				if (stat.hit) op = OP_SLOT_RD;
				else if (stat.command == CMD_UPSERT && stat.free_avail) op = OP_POP_RD;
				else if (stat.command == CMD_UPSERT && stat.slot_avail) op = OP_NEW_SLOT;
				else if (stat.command == CMD_UPSERT) op = OP_RES_FULL;
				else op = OP_RES_NF;
			end
			S_HSLOT_CMP: op = stat.gen_match ? OP_REC_RD : OP_RES_NF;
			S_SLOT_CMP:  op = OP_REC_RD;
			S_REC_CMP: begin
				if (stat.command == CMD_REMOVE) op = OP_DEL_START;
				else if (stat.command == CMD_UPSERT) op = OP_RES_UPD;
				else op = OP_RES_FIND;
			end
			S_LAST_CMP:  op = OP_MOVE;
			S_DEL_PREP:  op = OP_DEL_PREP;
			S_DEL_SHIFT: op = OP_DEL_SHIFT;
			S_DEL_FIN:   op = OP_DEL_FIN;
			S_POP_CMP:   op = OP_POP_GEN;
			S_POP_GEN:   op = OP_GEN_LATCH;
			S_ALLOC:     op = OP_ALLOC;
			S_INS_SHIFT: op = OP_INS_SHIFT;
			S_INS_FIN:   op = OP_INS_FIN;
			default:     op = OP_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/khtab_dp.sv =====
// Datapath of the handle table: stores, counters and result register.
module khtab_dp import khtab_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	input  req_t     request,
	input  op_t      op,
	output dp_stat_t stat,
	output rsp_t     response,
	output logic     done
);

	logic          enabled_q;
	logic [CW-1:0] len_q, used_q, fd_q, total_q;
	logic [31:0]   grev_q;
	logic [DEPTH-1:0] alive_q;
	logic          done_q;

	req_t          req_q;
	logic [CW-1:0] lo_q, n_q, pos_q, i_q;
	logic [AW-1:0] s_q, r_q;
	logic [31:0]   gen_q;
	rsp_t          rsp_q;

	logic          idx_we, gen_we, srec_we, fs_we, rec_we;
	logic [AW-1:0] idx_waddr, idx_raddr, gen_waddr, gen_raddr, srec_waddr, srec_raddr;
	logic [AW-1:0] fs_waddr, fs_raddr, rec_waddr, rec_raddr;
	idx_t          idx_wdata, idx_rd;
	logic [31:0]   gen_wdata, gen_rd;
	logic [AW-1:0] srec_wdata, srec_rd, fs_wdata, fs_rd;
	rec_t          rec_wdata, rec_rd;
	logic [2:0]    err_status;

	logic [CW-1:0] half, mid, len_m1, fd_m1, total_m1, pos_p1, i_m2, i_p2;

	assign half     = n_q >> 1;
	assign mid      = lo_q + half;
	assign len_m1   = len_q - CW'(1);
	assign fd_m1    = fd_q - CW'(1);
	assign total_m1 = total_q - CW'(1);
	assign pos_p1   = pos_q + CW'(1);
	assign i_m2     = i_q - CW'(2);
	assign i_p2     = i_q + CW'(2);

	khtab_ram #(.WIDTH($bits(idx_t)), .DEPTH(DEPTH)) u_idx (
		.clk(clk), .we(idx_we), .waddr(idx_waddr), .wdata(idx_wdata),
		.raddr(idx_raddr), .rdata(idx_rd)
	);
	khtab_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_gen (
		.clk(clk), .we(gen_we), .waddr(gen_waddr), .wdata(gen_wdata),
		.raddr(gen_raddr), .rdata(gen_rd)
	);
	khtab_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_srec (
		.clk(clk), .we(srec_we), .waddr(srec_waddr), .wdata(srec_wdata),
		.raddr(srec_raddr), .rdata(srec_rd)
	);
	khtab_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_fs (
		.clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
		.raddr(fs_raddr), .rdata(fs_rd)
	);
	khtab_ram #(.WIDTH($bits(rec_t)), .DEPTH(DEPTH)) u_rec (
		.clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
		.raddr(rec_raddr), .rdata(rec_rd)
	);

	always_comb begin
		idx_we = 1'b0; idx_waddr = '0; idx_wdata = '0; idx_raddr = '0;
		gen_we = 1'b0; gen_waddr = '0; gen_wdata = '0; gen_raddr = '0;
		srec_we = 1'b0; srec_waddr = '0; srec_wdata = '0; srec_raddr = '0;
		fs_we = 1'b0; fs_waddr = '0; fs_wdata = '0; fs_raddr = '0;
		rec_we = 1'b0; rec_waddr = '0; rec_wdata = '0; rec_raddr = '0;
		case (op)
			OP_HRD: begin
				gen_raddr  = req_q.handle_slot[AW-1:0];
				srec_raddr = req_q.handle_slot[AW-1:0];
			end
			OP_MID_RD: idx_raddr = mid[AW-1:0];
			OP_HIT_RD: idx_raddr = lo_q[AW-1:0];
			OP_SLOT_RD: begin
				gen_raddr  = idx_rd.slot;
				srec_raddr = idx_rd.slot;
			end
			OP_REC_RD:  rec_raddr = srec_rd;
			OP_POP_RD:  fs_raddr = fd_m1[AW-1:0];
			OP_POP_GEN: gen_raddr = fs_rd;
			OP_NEW_SLOT: begin
				gen_we    = 1'b1;
				gen_waddr = used_q[AW-1:0];
				gen_wdata = 32'd1;
			end
			OP_ALLOC: begin
				rec_we     = 1'b1;
				rec_waddr  = total_q[AW-1:0];
				rec_wdata  = '{key: req_q.key, owner: s_q, rev: 32'd1};
				srec_we    = 1'b1;
				srec_waddr = s_q;
				srec_wdata = total_q[AW-1:0];
				idx_raddr  = len_m1[AW-1:0];
			end
			OP_INS_SHIFT: begin
				idx_we    = 1'b1;
				idx_waddr = i_q[AW-1:0];
				idx_wdata = idx_rd;
				idx_raddr = i_m2[AW-1:0];
			end
			OP_INS_FIN: begin
				idx_we    = 1'b1;
				idx_waddr = pos_q[AW-1:0];
				idx_wdata = '{key: req_q.key, slot: s_q};
			end
			OP_RES_UPD: begin
				rec_we    = 1'b1;
				rec_waddr = r_q;
				rec_wdata = '{key: rec_rd.key, owner: rec_rd.owner, rev: rec_rd.rev + 32'd1};
			end
			OP_DEL_START: begin
				gen_we    = 1'b1;
				gen_waddr = s_q;
				gen_wdata = gen_q + 32'd1;
				fs_we     = (fd_q < CW'(DEPTH));
				fs_waddr  = fd_q[AW-1:0];
				fs_wdata  = s_q;
				rec_raddr = total_m1[AW-1:0];
			end
			OP_MOVE: begin
				rec_we     = 1'b1;
				rec_waddr  = r_q;
				rec_wdata  = rec_rd;
				srec_we    = 1'b1;
				srec_waddr = rec_rd.owner;
				srec_wdata = r_q;
			end
			OP_DEL_PREP: idx_raddr = pos_p1[AW-1:0];
			OP_DEL_SHIFT: begin
				idx_we    = 1'b1;
				idx_waddr = i_q[AW-1:0];
				idx_wdata = idx_rd;
				idx_raddr = i_p2[AW-1:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		case (op)
			OP_RES_DIS:  err_status = ST_DISABLED;
			OP_RES_ZK:   err_status = ST_ZERO_KEY;
			OP_RES_FULL: err_status = ST_FULL;
			default:     err_status = ST_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			len_q     <= '0;
			used_q    <= '0;
			fd_q      <= '0;
			total_q   <= '0;
			grev_q    <= '0;
			alive_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				enabled_q <= cfg_wdata;
				len_q     <= '0;
				used_q    <= '0;
				fd_q      <= '0;
				total_q   <= '0;
				grev_q    <= '0;
				alive_q   <= '0;
			end else begin
				case (op)
					OP_RES_DIS, OP_RES_NF, OP_RES_ZK, OP_RES_FULL, OP_RES_FIND: done_q <= 1'b1;
					OP_RES_UPD: begin
						grev_q <= grev_q + 32'd1;
						done_q <= 1'b1;
					end
					OP_POP_RD:   fd_q <= fd_m1;
					OP_NEW_SLOT: used_q <= used_q + CW'(1);
					OP_ALLOC: begin
						total_q      <= total_q + CW'(1);
						alive_q[s_q] <= 1'b1;
					end
					OP_INS_FIN, OP_DEL_FIN: begin
						len_q  <= (op == OP_INS_FIN) ? len_q + CW'(1) : len_m1;
						grev_q <= grev_q + 32'd1;
						done_q <= 1'b1;
					end
					OP_DEL_START: begin
						alive_q[s_q] <= 1'b0;
						if (fd_q < CW'(DEPTH)) fd_q <= fd_q + CW'(1);
						total_q <= total_m1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				req_q <= request;
				lo_q  <= '0;
				n_q   <= len_q;
			end
			OP_SRCH_UPD: begin
				if (idx_rd.key < req_q.key) begin
					lo_q <= mid + CW'(1);
					n_q  <= n_q - half - CW'(1);
				end else begin
					n_q <= half;
				end
			end
			OP_HIT_RD: pos_q <= lo_q;
			OP_HRD:    s_q <= req_q.handle_slot[AW-1:0];
			OP_SLOT_RD: s_q <= idx_rd.slot;
			OP_REC_RD: begin
				gen_q <= gen_rd;
				r_q   <= srec_rd;
			end
			OP_POP_GEN:   s_q <= fs_rd;
			OP_GEN_LATCH: gen_q <= gen_rd;
			OP_NEW_SLOT: begin
				s_q   <= used_q[AW-1:0];
				gen_q <= 32'd1;
			end
			OP_ALLOC:     i_q <= len_q;
			OP_INS_SHIFT: i_q <= i_q - CW'(1);
			OP_DEL_PREP:  i_q <= pos_q;
			OP_DEL_SHIFT: i_q <= i_q + CW'(1);
			OP_RES_DIS, OP_RES_NF, OP_RES_ZK, OP_RES_FULL: begin
				rsp_q <= '{status: err_status, was_update: 1'b0, out_slot: 6'd0,
					out_generation: 32'd0, out_key: 32'd0, record_revision: 32'd0,
					live_count: 7'(total_q), table_revision: grev_q};
			end
			OP_RES_FIND, OP_RES_UPD, OP_DEL_START: begin
				rsp_q.status          <= ST_OK;
				rsp_q.was_update      <= (op == OP_RES_UPD);
				rsp_q.out_slot        <= 6'(s_q);
				rsp_q.out_generation  <= gen_q;
				rsp_q.out_key         <= rec_rd.key;
				rsp_q.record_revision <= (op == OP_RES_UPD) ? rec_rd.rev + 32'd1 : rec_rd.rev;
				rsp_q.live_count      <= 7'(total_q);
				rsp_q.table_revision  <= (op == OP_RES_UPD) ? grev_q + 32'd1 : grev_q;
			end
			OP_DEL_FIN: begin
				rsp_q.live_count     <= 7'(total_q);
				rsp_q.table_revision <= grev_q + 32'd1;
			end
			OP_INS_FIN: begin
				rsp_q.status          <= ST_OK;
				rsp_q.was_update      <= 1'b0;
				rsp_q.out_slot        <= 6'(s_q);
				rsp_q.out_generation  <= gen_q;
				rsp_q.out_key         <= req_q.key;
				rsp_q.record_revision <= 32'd1;
				rsp_q.live_count      <= 7'(total_q);
				rsp_q.table_revision  <= grev_q + 32'd1;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.enabled      = enabled_q;
		stat.command      = req_q.command;
		stat.key_zero     = (req_q.key == 32'd0);
		stat.handle_live  = (CW'(req_q.handle_slot) < used_q)
		                    && alive_q[req_q.handle_slot[AW-1:0]];
		stat.gen_match    = (gen_rd == req_q.handle_generation);
		stat.n_zero       = (n_q == '0);
		stat.hit          = (pos_q < len_q) && (idx_rd.key == req_q.key);
		stat.free_avail   = (fd_q != '0);
		stat.slot_avail   = (used_q < CW'(DEPTH));
		stat.last_differs = (CW'(r_q) != total_m1);
		stat.ins_first    = (len_q > pos_q);
		stat.ins_more     = (i_q > pos_p1);
		stat.del_first    = (pos_p1 < len_q);
		stat.del_more     = (i_p2 < len_q);
	end

	assign response = rsp_q;
	assign done     = done_q;

endmodule

// ===== hw/rtl/keyed_generational_handle_table.sv =====
// Top level of the keyed generational handle table.
//
//   channel   ports                  beat taken when
//   command   start, request, busy   start high and busy low
//   result    done, response         done high, one cycle, no stall
//   config    cfg_we, cfg_wdata      cfg_we high
//
// One command at a time; busy stays high until its result beat.
// Disabled, zero key and dead handle commands are decided at decode, a stale handle
// at its generation compare, a handle hit after its record read; key commands run a
// binary search (up to 7 steps) and insert or remove also shift the index entries.
// Reset and a config write clear the table; the result beat cannot stall.
module keyed_generational_handle_table import khtab_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output logic done,
	output rsp_t response,
	input  logic cfg_we,
	input  logic cfg_wdata
);

	op_t      op;
	dp_stat_t stat;

	khtab_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .op(op), .busy(busy)
	);

	khtab_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.request(request), .op(op), .stat(stat), .response(response), .done(done)
	);

endmodule

// ===== hw/rtl/khtab_chk.sv =====
// Port-level checker of the handle table and its bind.
module khtab_chk import khtab_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t response
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("command beat did not raise busy");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back to back result beats");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && response.status != ST_OK |-> response.out_key == 32'd0
		&& response.record_revision == 32'd0 && !response.was_update)
		else $error("error result carries record fields");

	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> response.live_count <= 7'(DEPTH)) else $error("live count too large");

endmodule

bind keyed_generational_handle_table khtab_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.response(response)
);
